[src/sm3bc_pkg.sv]
`default_nettype none
package sm3bc_pkg;

    // Block and round geometry
    localparam int BLOCK_WORDS  = 16;
    localparam int ROUNDS       = 64;
    localparam int DIGEST_WORDS = 8;
    localparam int FIFO_DEPTH   = 4;

    localparam int POS_W   = $clog2(BLOCK_WORDS);
    localparam int ROUND_W = $clog2(ROUNDS);
    localparam int DIG_W   = $clog2(DIGEST_WORDS);
    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [POS_W-1:0]   LAST_POS       = POS_W'(BLOCK_WORDS - 1);
    localparam logic [ROUND_W-1:0] LAST_ROUND     = ROUND_W'(ROUNDS - 1);
    localparam logic [ROUND_W-1:0] LAST_LOW_ROUND = ROUND_W'(15);
    localparam logic [DIG_W-1:0]   LAST_DIG       = DIG_W'(DIGEST_WORDS - 1);

    // Round constants
    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    // T_HIGH rotated left by 16, the constant in round sixteen
    localparam logic [31:0] T_HIGH_ROT16 = {T_HIGH[15:0], T_HIGH[31:16]};

    typedef logic [31:0] word_t;

    localparam word_t IV [DIGEST_WORDS] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    // Input item
    typedef struct packed {
        logic [31:0] message_word;
        logic        start_message;
        logic        final_block;
    } msg_t;

    // Result item
    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } dig_t;

    // Classified word handed from front to back
    typedef struct packed {
        logic [31:0] word;
        logic        first;
        logic        last;
        logic        restart;
        logic        fin;
    } blk_word_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_LOAD,
        BK_ROUND,
        BK_UPDATE,
        BK_EMIT
    } bk_state_t;

    // Rotate left by a constant amount
    function automatic word_t rotl(input word_t x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic word_t perm0(input word_t x);
        return x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic word_t perm1(input word_t x);
        return x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

endpackage
`default_nettype wire

[src/sm3bc_fifo.sv]
`default_nettype none
module sm3bc_fifo
    import sm3bc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire blk_word_t push_data,
    output logic           full,
    input  wire logic      pop,
    output blk_word_t      pop_data,
    output logic           not_empty
);

    blk_word_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  do_push, do_pop;

    assign full      = (count_reg == CNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

[src/sm3bc_front.sv]
`default_nettype none
module sm3bc_front
    import sm3bc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  msg_valid,
    output logic       msg_stall,
    input  wire msg_t  msg,
    output logic       push,
    output blk_word_t  push_data,
    input  wire logic  full
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             accept;

    assign msg_stall = full;
    assign accept    = msg_valid && !full;
    assign push      = accept;

    // Tag each word with its place in the block; flags count on the first word only
    always_comb
    begin
        push_data.word    = msg.message_word;
        push_data.first   = (pos_reg == '0);
        push_data.last    = (pos_reg == LAST_POS);
        push_data.restart = (pos_reg == '0) && msg.start_message;
        push_data.fin     = (pos_reg == '0) && msg.final_block;
        pos_next          = accept ? pos_reg + POS_W'(1) : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule
`default_nettype wire

[src/sm3bc_back.sv]
`default_nettype none
module sm3bc_back
    import sm3bc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fifo_not_empty,
    input  wire blk_word_t fifo_data,
    output logic           pop,
    output logic           dig_valid,
    input  wire logic      dig_stall,
    output dig_t           dig
);

    bk_state_t          state_reg, state_next;
    logic [ROUND_W-1:0] round_reg;
    logic [DIG_W-1:0]   emit_cnt_reg;
    logic               final_reg;
    word_t              tj_reg;
    word_t              chain_reg [DIGEST_WORDS];
    word_t              w_reg [BLOCK_WORDS];
    word_t              a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic               out_valid_reg, out_valid_next;
    dig_t               out_item_reg;

    // FSM output controls
    logic               load_word;
    logic               start_rounds;
    logic               do_round;
    logic               do_update;
    logic               emit_word;

    // Round datapath
    word_t              a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
    logic               out_free;

    assign out_free  = !out_valid_reg || !dig_stall;
    assign dig_valid = out_valid_reg;
    assign dig       = out_item_reg;
    assign pop       = load_word;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_LOAD:
            begin
                if (fifo_not_empty && fifo_data.last)
                begin
                    state_next = BK_ROUND;
                end
            end
            BK_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = BK_UPDATE;
                end
            end
            BK_UPDATE:
            begin
                state_next = final_reg ? BK_EMIT : BK_LOAD;
            end
            BK_EMIT:
            begin
                if (out_free && (emit_cnt_reg == LAST_DIG))
                begin
                    state_next = BK_LOAD;
                end
            end
            default:
            begin
                state_next = BK_LOAD;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        load_word    = 1'b0;
        start_rounds = 1'b0;
        do_round     = 1'b0;
        do_update    = 1'b0;
        emit_word    = 1'b0;
        case (state_reg)
            BK_LOAD:
            begin
                load_word    = fifo_not_empty;
                start_rounds = fifo_not_empty && fifo_data.last;
            end
            BK_ROUND:
            begin
                do_round = 1'b1;
            end
            BK_UPDATE:
            begin
                do_update = 1'b1;
            end
            BK_EMIT:
            begin
                emit_word = out_free;
            end
            default:
            begin
                load_word = 1'b0;
            end
        endcase
    end

    // One compression round and one expanded schedule word
    always_comb
    begin
        a12 = rotl(a_reg, 12);
        ss1 = rotl(a12 + e_reg + tj_reg, 7);
        ss2 = ss1 ^ a12;
        if (round_reg <= LAST_LOW_ROUND)
        begin
            ff = a_reg ^ b_reg ^ c_reg;
            gg = e_reg ^ f_reg ^ g_reg;
        end
        else
        begin
            ff = (a_reg & b_reg) | (a_reg & c_reg) | (b_reg & c_reg);
            gg = (e_reg & f_reg) | (~e_reg & g_reg);
        end
        tt1   = ff + d_reg + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2   = gg + h_reg + ss1 + w_reg[0];
        w_new = perm1(w_reg[0] ^ w_reg[7] ^ rotl(w_reg[13], 15))
                ^ rotl(w_reg[3], 7) ^ w_reg[10];
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg && dig_stall;
        if (emit_word)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_LOAD;
            round_reg     <= '0;
            emit_cnt_reg  <= '0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_reg[i] <= IV[i];
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (load_word && fifo_data.first)
            begin
                final_reg <= fifo_data.fin;
                if (fifo_data.restart)
                begin
                    for (int i = 0; i < DIGEST_WORDS; i++)
                    begin
                        chain_reg[i] <= IV[i];
                    end
                end
            end
            if (start_rounds)
            begin
                round_reg <= '0;
            end
            else if (do_round)
            begin
                round_reg <= round_reg + ROUND_W'(1);
            end
            if (do_update)
            begin
                chain_reg[0] <= chain_reg[0] ^ a_reg;
                chain_reg[1] <= chain_reg[1] ^ b_reg;
                chain_reg[2] <= chain_reg[2] ^ c_reg;
                chain_reg[3] <= chain_reg[3] ^ d_reg;
                chain_reg[4] <= chain_reg[4] ^ e_reg;
                chain_reg[5] <= chain_reg[5] ^ f_reg;
                chain_reg[6] <= chain_reg[6] ^ g_reg;
                chain_reg[7] <= chain_reg[7] ^ h_reg;
                emit_cnt_reg <= '0;
            end
            else if (emit_word)
            begin
                emit_cnt_reg <= emit_cnt_reg + DIG_W'(1);
            end
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        // message window: shift in while loading, expand while rounding
        if (load_word || do_round)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[BLOCK_WORDS - 1] <= load_word ? fifo_data.word : w_new;
        end
        if (start_rounds)
        begin
            tj_reg <= T_LOW;
            a_reg  <= chain_reg[0];
            b_reg  <= chain_reg[1];
            c_reg  <= chain_reg[2];
            d_reg  <= chain_reg[3];
            e_reg  <= chain_reg[4];
            f_reg  <= chain_reg[5];
            g_reg  <= chain_reg[6];
            h_reg  <= chain_reg[7];
        end
        else if (do_round)
        begin
            tj_reg <= (round_reg == LAST_LOW_ROUND) ? T_HIGH_ROT16 : rotl(tj_reg, 1);
            a_reg  <= tt1;
            b_reg  <= a_reg;
            c_reg  <= rotl(b_reg, 9);
            d_reg  <= c_reg;
            e_reg  <= perm0(tt2);
            f_reg  <= e_reg;
            g_reg  <= rotl(f_reg, 19);
            h_reg  <= g_reg;
        end
        if (emit_word)
        begin
            out_item_reg.digest_word <= chain_reg[emit_cnt_reg];
            out_item_reg.digest_last <= (emit_cnt_reg == LAST_DIG);
        end
    end

endmodule
`default_nettype wire

[src/sm3_block_compress_top.sv]
// SM3 block compressor.
// msg channel: one big-endian 32-bit word of a padded message per item,
// sixteen items per 512-bit block. start_message and final_block count on
// a block's first word only: start_message restarts the chain from the IV,
// final_block asks for the digest once the block is compressed.
// dig channel: eight items per final block, digest word 0 first,
// digest_last set on the eighth.
// Words pass a four-entry queue into the back end, which shifts them into
// the message window at one per cycle while the queue holds words, then
// runs 64 rounds at one round per cycle with on-the-fly message expansion,
// then folds the working registers into the chain by XOR. A final block
// then also emits the eight digest words.
// While rounds run, the queue absorbs up to four words of the next block.
// A stall on dig holds the output register and, during digest emission, the
// back end; the front keeps taking words until the queue is full. Reset loads
// the IV into the chain and empties the queue and the output register.
`default_nettype none
module sm3_block_compress_top
    import sm3bc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic msg_valid,
    output logic      msg_stall,
    input  wire msg_t msg,
    output logic      dig_valid,
    input  wire logic dig_stall,
    output dig_t      dig
);

    logic      push, full, pop, not_empty;
    blk_word_t push_data, pop_data;

    sm3bc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    sm3bc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    sm3bc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .fifo_not_empty (not_empty),
        .fifo_data      (pop_data),
        .pop            (pop),
        .dig_valid      (dig_valid),
        .dig_stall      (dig_stall),
        .dig            (dig)
    );

endmodule
`default_nettype wire

[dv/sm3_block_compress_top_test.sv]
`timescale 1ns / 1ps
module sm3_block_compress_top_test;
    import sm3bc_pkg::*;

    // Word patterns for whole blocks
    typedef enum int {
        PAT_RANDOM,
        PAT_ABC,
        PAT_ONES,
        PAT_ALT
    } pattern_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic msg_valid = 1'b0;
    logic msg_stall;
    msg_t msg = '0;
    logic dig_valid;
    logic dig_stall = 1'b0;
    dig_t dig;

    sm3_block_compress_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig       (dig)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stimulus and expectations
    msg_t word_queue[$];
    bit   hold_queue[$];
    dig_t digest_expected[$];

    int words_total    = 0;
    int words_accepted = 0;
    int blocks_total   = 0;
    int final_blocks   = 0;
    int digests_seen   = 0;
    int errors         = 0;
    bit calm           = 1'b0;

    // Predictor state
    logic [31:0] chain [DIGEST_WORDS];
    logic [31:0] sched [BLOCK_WORDS];
    logic [3:0]  blk_pos;
    logic        fin_latched;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
        int unsigned k;
        k = n % 32;
        if (k == 0)
            return x;
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic logic [31:0] mix_p0(input logic [31:0] x);
        return x ^ rol32(x, 9) ^ rol32(x, 17);
    endfunction

    function automatic logic [31:0] mix_p1(input logic [31:0] x);
        return x ^ rol32(x, 15) ^ rol32(x, 23);
    endfunction

    // Expand the block, run 64 rounds and fold the result into the chain
    function automatic void compress_block();
        logic [31:0] w [68];
        logic [31:0] wx [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
        for (int j = 0; j < 16; j++)
            w[j] = sched[j];
        for (int j = 16; j < 68; j++)
            w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15)) ^ rol32(w[j-13], 7) ^ w[j-6];
        for (int j = 0; j < 64; j++)
            wx[j] = w[j] ^ w[j+4];
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int j = 0; j < 64; j++)
        begin
            tj  = (j < 16) ? T_LOW : T_HIGH;
            a12 = rol32(a, 12);
            ss1 = rol32(a12 + e + rol32(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16)
            begin
                ff = a ^ b ^ c;
                gg = e ^ f ^ g;
            end
            else
            begin
                ff = (a & b) | (a & c) | (b & c);
                gg = (e & f) | (~e & g);
            end
            tt1 = ff + d + ss2 + wx[j];
            tt2 = gg + h + ss1 + w[j];
            d = c;
            c = rol32(b, 9);
            b = a;
            a = tt1;
            h = g;
            g = rol32(f, 19);
            f = e;
            e = mix_p0(tt2);
        end
        chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
        chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
    endfunction

    // Take one accepted word; queue the digest when a final block completes
    function automatic void sm3_absorb_word(input msg_t m);
        dig_t r;
        if (blk_pos == 0)
        begin
            if (m.start_message)
                for (int k = 0; k < DIGEST_WORDS; k++)
                    chain[k] = IV[k];
            fin_latched = m.final_block;
        end
        sched[blk_pos] = m.message_word;
        if (blk_pos != LAST_POS)
        begin
            blk_pos++;
            return;
        end
        blk_pos = '0;
        compress_block();
        if (fin_latched)
        begin
            fin_latched = 1'b0;
            for (int k = 0; k < DIGEST_WORDS; k++)
            begin
                r.digest_word = chain[k];
                r.digest_last = (k == DIGEST_WORDS - 1);
                digest_expected.push_back(r);
            end
        end
    endfunction

    // Queue one 16-word block; flags on later words are noise the block ignores
    task automatic add_block(input logic start, input logic fin, input pattern_t pat,
                             input bit hold_first);
        msg_t m;
        for (int i = 0; i < BLOCK_WORDS; i++)
        begin
            case (pat)
                PAT_ABC:  m.message_word = (i == 0) ? 32'h61626380 :
                                           (i == 15) ? 32'h00000018 : 32'h0;
                PAT_ONES: m.message_word = 32'hFFFFFFFF;
                PAT_ALT:  m.message_word = (i % 2) ? 32'hFFFFFFFF : 32'h0;
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                        m.message_word = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
                    else
                        m.message_word = $urandom;
                end
            endcase
            if (i == 0)
            begin
                m.start_message = start;
                m.final_block   = fin;
            end
            else if (pat == PAT_RANDOM)
            begin
                m.start_message = 1'($urandom_range(0, 1));
                m.final_block   = 1'($urandom_range(0, 1));
            end
            else
            begin
                m.start_message = 1'b1;
                m.final_block   = 1'b1;
            end
            word_queue.push_back(m);
            hold_queue.push_back(hold_first && (i == 0));
        end
        words_total += BLOCK_WORDS;
        blocks_total++;
        if (fin)
            final_blocks++;
    endtask

    // Message driver
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_valid <= 1'b0;
            msg       <= '0;
            gap_left  = 0;
            blk_pos   = '0;
            fin_latched = 1'b0;
            for (int k = 0; k < DIGEST_WORDS; k++)
                chain[k] = IV[k];
        end
        else
        begin
            if (msg_valid && !msg_stall)
            begin
                sm3_absorb_word(msg);
                words_accepted++;
            end
            calm = (word_queue.size() < 2 * BLOCK_WORDS);
            if (!(msg_valid && msg_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    msg_valid <= 1'b0;
                end
                else if (word_queue.size() == 0)
                    msg_valid <= 1'b0;
                else if (hold_queue[0] && digest_expected.size() != 0)
                    msg_valid <= 1'b0;
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    gap_left = $urandom_range(1, 18) - 1;
                    msg_valid <= 1'b0;
                end
                else
                begin
                    msg <= word_queue.pop_front();
                    void'(hold_queue.pop_front());
                    msg_valid <= 1'b1;
                end
            end
        end
    end

    // Digest monitor and checker
    int stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        dig_t exp_r;
        if (!rst_n)
        begin
            dig_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (dig_valid && !dig_stall)
            begin
                digests_seen++;
                if (digest_expected.size() == 0)
                begin
                    $error("unexpected digest item: word %h last %b",
                           dig.digest_word, dig.digest_last);
                    errors++;
                end
                else
                begin
                    exp_r = digest_expected.pop_front();
                    if (dig.digest_word !== exp_r.digest_word)
                    begin
                        $error("digest_word: expected %h, got %h",
                               exp_r.digest_word, dig.digest_word);
                        errors++;
                    end
                    if (dig.digest_last !== exp_r.digest_last)
                    begin
                        $error("digest_last: expected %b, got %b",
                               exp_r.digest_last, dig.digest_last);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                dig_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                dig_stall <= 1'b1;
            end
            else
                dig_stall <= 1'b0;
        end
    end

    // Stimulus plan and end of run
    initial
    begin
        int rand_finals;
        pattern_t pat;
        rand_finals = 0;

        // Directed: first block after reset without start, then all-ones with start
        add_block(1'b0, 1'b1, PAT_ABC, 1'b0);
        add_block(1'b1, 1'b0, PAT_ONES, 1'b0);

        // Random blocks; wait for the digest queue to drain before two of them
        while (blocks_total < 11 || rand_finals < 5)
        begin
            pat = ($urandom_range(0, 9) == 0) ? PAT_ALT : PAT_RANDOM;
            add_block(1'($urandom_range(0, 1)), $urandom_range(0, 2) != 0, pat,
                      blocks_total == 2 || blocks_total == 6);
            if (word_queue[$-15].final_block)
                rand_finals++;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (words_accepted == words_total);
        wait (digest_expected.size() == 0);
        repeat (120) @(posedge clk);

        $display("Covered %0d message words in %0d blocks (%0d final),",
                 words_accepted, blocks_total, final_blocks);
        $display("with %0d digest words checked.", digests_seen);
        if (errors == 0 && digest_expected.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
